// File: rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared constants, character codes and the job record passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sdf_pkg;

  localparam int DIGIT_SLOTS = 10;
  localparam int VALUE_W     = 32;
  localparam int FIELD_W     = 4;
  localparam int CHAR_W      = 7;

  // count and point are compared in a common width
  localparam int CNT_W = ($clog2(DIGIT_SLOTS + 1) > FIELD_W) ?
                         $clog2(DIGIT_SLOTS + 1) : FIELD_W;
  localparam int DIG_W = ($clog2(DIGIT_SLOTS) > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int BCD_W = 4 * DIGIT_SLOTS;

  // binary to bcd conversion, bits consumed per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = ($clog2(STEPS) > 1) ? $clog2(STEPS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = ($clog2(QUEUE_DEPTH) > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_POINT = 7'h2E;

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   point;
    logic               point_en;
  } sdf_job_t;

endpackage

// File: rtl/sdf_in_if.sv
// ----------------------------------------------------------------------------
// sdf_in_if
// Input channel: one number with its digit count and point position.
// ----------------------------------------------------------------------------
interface sdf_in_if import sdf_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [FIELD_W-1:0]        digit_count;
  logic [FIELD_W-1:0]        point_position;

  modport source (output valid, output value, output digit_count,
                  output point_position, input ready);
  modport sink   (input valid, input value, input digit_count,
                  input point_position, output ready);
endinterface

// File: rtl/sdf_out_if.sv
// ----------------------------------------------------------------------------
// sdf_out_if
// Output channel: one ASCII character per word, last marks the end of a number.
// ----------------------------------------------------------------------------
interface sdf_out_if import sdf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// File: rtl/sdf_front.sv
// ----------------------------------------------------------------------------
// sdf_front
// Accepts numbers, takes sign and magnitude, saturates the digit count and
// decides whether a point is shown; registers the job for the queue.
// ----------------------------------------------------------------------------
module sdf_front import sdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  sdf_in_if.sink   in,
  output logic     job_valid,
  input  logic     job_ready,
  output sdf_job_t job
);

  logic [VALUE_W-1:0] raw;
  logic [CNT_W-1:0]   cnt_in;
  logic [CNT_W-1:0]   pt_in;
  sdf_job_t           cls;

  always_comb begin
    raw          = VALUE_W'(in.value);
    cnt_in       = CNT_W'(in.digit_count);
    pt_in        = CNT_W'(in.point_position);
    cls.negative = raw[VALUE_W-1];
    // most negative value comes out as its unsigned magnitude
    cls.mag      = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
    cls.count    = (cnt_in > CNT_W'(DIGIT_SLOTS)) ? CNT_W'(DIGIT_SLOTS) : cnt_in;
    cls.point    = pt_in;
    cls.point_en = (pt_in != '0) && (pt_in <= cls.count);
  end

  assign in.ready = !job_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in.ready) begin
      job_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      job <= cls;
    end
  end

endmodule

// File: rtl/sdf_queue.sv
// ----------------------------------------------------------------------------
// sdf_queue
// Short job queue between front and back end.
// ----------------------------------------------------------------------------
module sdf_queue import sdf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  sdf_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output sdf_job_t pop_job
);

  sdf_job_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QFILL_W-1:0]  fill;
  logic                push;
  logic                pop;

  assign push_ready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

// File: rtl/sdf_back.sv
// ----------------------------------------------------------------------------
// sdf_back
// Converts the magnitude to decimal by shift-and-add-3, four bits a cycle,
// then emits sign, digits and point one character per word.
// ----------------------------------------------------------------------------
module sdf_back import sdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  output logic      job_ready,
  input  sdf_job_t  job,
  sdf_out_if.source out
);

  function automatic logic [BCD_W-1:0] dabble_bit(input logic [BCD_W-1:0] bcd,
                                                  input logic b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGIT_SLOTS; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // converter
  logic               conv_busy;
  logic               conv_done;
  logic [STEP_W-1:0]  step;
  logic [VALUE_W-1:0] sh;
  logic [BCD_W-1:0]   bcd;
  sdf_job_t           conv_job;
  logic [BCD_W-1:0]   bcd_next;

  // emitter
  logic               em_active;
  logic               sign_pend;
  logic               dot_done;
  logic [CNT_W-1:0]   pos;
  logic [BCD_W-1:0]   em_digits;
  sdf_job_t           em_job;
  logic               o_valid;
  logic [CHAR_W-1:0]  o_char;
  logic               o_last;

  logic               load_em;
  logic               advance;
  logic [CNT_W-1:0]   pos_dec;
  logic [DIG_W-1:0]   dig_idx;
  logic [3:0]         digit;
  logic [CHAR_W-1:0]  char_next;
  logic               last_next;

  assign job_ready = !conv_busy;
  assign load_em   = conv_done && !em_active;

  always_comb begin
    bcd_next = bcd;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      bcd_next = dabble_bit(bcd_next, sh[VALUE_W-1-k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_busy <= 1'b0;
      conv_done <= 1'b0;
    end else if (!conv_busy) begin
      conv_busy <= job_valid;
      conv_done <= 1'b0;
    end else if (!conv_done) begin
      if (step == STEP_W'(STEPS - 1)) begin
        conv_done <= 1'b1;
      end
    end else if (load_em) begin
      conv_busy <= 1'b0;
      conv_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!conv_busy && job_valid) begin
      step     <= '0;
      sh       <= job.mag;
      bcd      <= '0;
      conv_job <= job;
    end else if (conv_busy && !conv_done) begin
      step <= step + 1'b1;
      sh   <= sh << BITS_PER_STEP;
      bcd  <= bcd_next;
    end
  end

  // next character of the number being emitted
  assign advance = em_active && (!o_valid || out.ready);
  assign pos_dec = pos - CNT_W'(1);
  assign dig_idx = pos_dec[DIG_W-1:0];
  assign digit   = em_digits[4*dig_idx +: 4];

  always_comb begin
    if (sign_pend) begin
      char_next = em_job.negative ? CH_MINUS : CH_SPACE;
      last_next = (em_job.count == '0);
    end else if (em_job.point_en && (pos == em_job.point) && !dot_done) begin
      char_next = CH_POINT;
      last_next = 1'b0;
    end else begin
      char_next = CH_ZERO + CHAR_W'(digit);
      last_next = (pos == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_active <= 1'b0;
      o_valid   <= 1'b0;
    end else begin
      if (advance) begin
        o_valid <= 1'b1;
      end else if (o_valid && out.ready) begin
        o_valid <= 1'b0;
      end
      if (advance && last_next) begin
        em_active <= 1'b0;
      end else if (load_em) begin
        em_active <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_em) begin
      sign_pend <= 1'b1;
      dot_done  <= 1'b0;
      pos       <= conv_job.count;
      em_digits <= bcd;
      em_job    <= conv_job;
    end else if (advance) begin
      o_char <= char_next;
      o_last <= last_next;
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (char_next == CH_POINT) begin
        dot_done <= 1'b1;
      end else begin
        pos      <= pos_dec;
        dot_done <= 1'b0;
      end
    end
  end

  assign out.valid     = o_valid;
  assign out.char_code = o_char;
  assign out.last      = o_last;

endmodule

// File: rtl/signed_decimal_text_formatter_top.sv
// ----------------------------------------------------------------------------
// signed_decimal_text_formatter_top
// Formats signed 32-bit numbers as ASCII text: sign, low digits, optional point.
//
//   channel | dir | payload                              | word
//   in      | in  | value, digit_count, point_position   | one number
//   out     | out | char_code, last                      | one character
//
// In the converter a number goes through load, 8 steps of 4 bits and handoff;
// the output then carries 1 + digits (+1 for the point) words, up to 12.
// Conversion of one number overlaps output of the previous one.
// Synchronous reset clears the handshake, busy and queue state; no clearing pass is needed.
// A stalled output holds its word while the front end and queue keep accepting until the queue is full.
// ----------------------------------------------------------------------------
module signed_decimal_text_formatter_top import sdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  sdf_in_if.sink    in,
  sdf_out_if.source out
);

  logic     f_valid;
  logic     f_ready;
  sdf_job_t f_job;
  logic     q_valid;
  logic     q_ready;
  sdf_job_t q_job;

  sdf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in        (in),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job       (f_job)
  );

  sdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  sdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out       (out)
  );

endmodule

// File: rtl/sdf_chk.sv
// ----------------------------------------------------------------------------
// sdf_chk
// Port-level checks on the character stream of the formatter.
// ----------------------------------------------------------------------------
module sdf_chk import sdf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  // next word opens a new number
  logic expect_sign;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_sign <= 1'b1;
    end else if (out_valid && out_ready) begin
      expect_sign <= out_last;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_char >= CH_ZERO && out_char <= CH_ZERO + 7'd9) ||
                   out_char == CH_MINUS || out_char == CH_SPACE ||
                   (out_char == CH_POINT && !out_last)))
    else $error("illegal character or point ending a number");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (out_valid && expect_sign) |-> (out_char == CH_MINUS || out_char == CH_SPACE))
    else $error("number does not open with a sign");

  a_sign_once: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !expect_sign) |-> !(out_char == CH_MINUS || out_char == CH_SPACE))
    else $error("sign inside a number");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(out_last)))
    else $error("stalled word changed");

endmodule

bind signed_decimal_text_formatter_top sdf_chk u_sdf_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_char  (out.char_code),
  .out_last  (out.last)
);

// File: test/sdf_text_checker.sv
// ----------------------------------------------------------------------------
// sdf_text_checker
// Watches both channels of the formatter. Every accepted number is turned
// into its expected character words, and every accepted output word is
// compared with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module sdf_text_checker import sdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  sdf_in_if    in_mon,
  sdf_out_if   out_mon,
  output int   fail_count,
  output int   pending_words,
  output int   numbers_seen,
  output int   chars_seen,
  output int   negatives_seen
);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_word_t;

  text_word_t expected_text [$];
  text_word_t oldest;

  // sign, then the low digits most significant first, '.' ahead of the
  // digit whose position from the right matches the point position
  function automatic void predict_text(input logic [VALUE_W-1:0] raw,
                                       input logic [FIELD_W-1:0] dcount,
                                       input logic [FIELD_W-1:0] ppos);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         dec_digit [DIGIT_SLOTS];
    logic [CHAR_W-1:0]  glyphs [$];
    text_word_t         w;
    int                 shown;
    int                 i;
    mag   = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    shown = (dcount > DIGIT_SLOTS) ? DIGIT_SLOTS : int'(dcount);
    for (i = 0; i < DIGIT_SLOTS; i++) begin
      dec_digit[i] = 4'(mag % 10);
      mag          = mag / 10;
    end
    glyphs.push_back(raw[VALUE_W-1] ? CH_MINUS : CH_SPACE);
    for (i = shown; i > 0; i--) begin
      if (i == int'(ppos)) begin
        glyphs.push_back(CH_POINT);
      end
      glyphs.push_back(CH_ZERO + CHAR_W'(dec_digit[i-1]));
    end
    for (i = 0; i < glyphs.size(); i++) begin
      w.char_code = glyphs[i];
      w.last      = (i == glyphs.size() - 1);
      expected_text.push_back(w);
    end
  endfunction

  initial begin
    fail_count     = 0;
    pending_words  = 0;
    numbers_seen   = 0;
    chars_seen     = 0;
    negatives_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      // output first: a word can never belong to a number taken on the same edge
      if (out_mon.valid && out_mon.ready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          $error("unexpected word: char_code %h last %b", out_mon.char_code,
                 out_mon.last);
          fail_count++;
        end else begin
          oldest = expected_text.pop_front();
          if (out_mon.char_code !== oldest.char_code) begin
            $error("char_code: expected %h, got %h", oldest.char_code,
                   out_mon.char_code);
            fail_count++;
          end
          if (out_mon.last !== oldest.last) begin
            $error("last: expected %b, got %b", oldest.last, out_mon.last);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_text(in_mon.value, in_mon.digit_count, in_mon.point_position);
        numbers_seen++;
        if (in_mon.value[VALUE_W-1]) begin
          negatives_seen++;
        end
      end
      pending_words = expected_text.size();
    end
  end

endmodule

// File: test/tb_signed_decimal_text_formatter_top.sv
// ----------------------------------------------------------------------------
// tb_signed_decimal_text_formatter_top
// Drives numbers into the formatter: a directed set of edge cases, then
// random numbers under mixed pacing, full-rate streaming, a long receiver
// hold-off and a drained pause. A checker beside the block predicts and
// compares every character word.
// ----------------------------------------------------------------------------
module tb_signed_decimal_text_formatter_top;
  import sdf_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 77;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 40;

  logic clk;
  logic rst;
  bit   full_speed;
  bit   hold_request;
  int   cycle_count;
  int   fail_count;
  int   pending_words;
  int   numbers_seen;
  int   chars_seen;
  int   negatives_seen;

  sdf_in_if  in_ch ();
  sdf_out_if out_ch ();

  signed_decimal_text_formatter_top dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  sdf_text_checker text_check (
    .clk            (clk),
    .rst            (rst),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .pending_words  (pending_words),
    .numbers_seen   (numbers_seen),
    .chars_seen     (chars_seen),
    .negatives_seen (negatives_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int random_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 30);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic send_number(input logic signed [VALUE_W-1:0] v,
                             input logic [FIELD_W-1:0] dc,
                             input logic [FIELD_W-1:0] pp);
    in_ch.value          <= v;
    in_ch.digit_count    <= dc;
    in_ch.point_position <= pp;
    in_ch.valid          <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    idle_sender((full_speed || $urandom_range(0, 1) == 0) ? 0 : random_gap());
  endtask

  task automatic send_random_number();
    logic signed [VALUE_W-1:0] v;
    logic [FIELD_W-1:0]        dc;
    logic [FIELD_W-1:0]        pp;
    case ($urandom_range(0, 3))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 999);
      2:       v = 0 - $urandom_range(0, 99999);
      default: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 15);
    endcase
    dc = FIELD_W'($urandom_range(0, 15));
    // mostly a point that lands inside the digits
    if (dc != 0 && $urandom_range(0, 2) != 0) begin
      pp = FIELD_W'($urandom_range(1, (dc > DIGIT_SLOTS) ? DIGIT_SLOTS : int'(dc)));
    end else begin
      pp = FIELD_W'($urandom_range(0, 15));
    end
    send_number(v, dc, pp);
  endtask

  // receiver side, the long hold-off is counted here
  initial begin : receiver
    int stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (full_speed || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        stall_left = random_gap() - 1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int phase;
    rst                  = 1'b1;
    full_speed           = 1'b0;
    hold_request         = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.value          = '0;
    in_ch.digit_count    = '0;
    in_ch.point_position = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_number(0, 1, 0);
    send_number(0, 0, 0);
    send_number(-7, 0, 3);                 // zero count, sign alone
    send_number(1, 10, 0);                 // leading zeros kept
    send_number(-1, 3, 1);
    send_number(32'sh7FFF_FFFF, 10, 10);   // point ahead of the top digit
    send_number(32'sh8000_0000, 10, 0);    // most negative value
    send_number(32'sh8000_0000, 15, 10);   // count saturates
    send_number(32'sh7FFF_FFFF, 11, 11);   // point beyond the saturated count
    send_number(123456789, 3, 0);          // high digits dropped
    send_number(-123456789, 4, 2);
    send_number(42, 6, 3);
    send_number(98765, 5, 5);
    send_number(98765, 5, 6);
    send_number(5, 15, 15);
    send_number(-99, 12, 1);
    send_number(1000000000, 10, 1);
    send_number(-1000000000, 9, 9);
    send_number(31415, 2, 2);
    send_number(-5, 1, 1);
    send_number(32'shAAAA_AAAA, 7, 4);
    send_number(32'sh5555_5555, 8, 8);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        1: full_speed = 1'b1;
        2: begin
          // receiver stops while the sender keeps pushing
          full_speed   = 1'b1;
          hold_request = 1'b1;
        end
        3: begin
          full_speed = 1'b0;
          idle_sender(1);
          while (pending_words != 0) @(negedge clk);
        end
        default: full_speed = 1'b0;
      endcase
      repeat (PHASE_ITEMS) send_random_number();
    end

    full_speed = 1'b0;
    idle_sender(1);
    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("formatted %0d numbers (%0d negative) into %0d character words",
             numbers_seen, negatives_seen, chars_seen);
    $display("pacing: random gaps, full-rate streaming, %0d-cycle receiver hold-off",
             LONG_HOLD);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
